@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker psc_chk.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with active-low reset disable.
`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// Expression that must never hold while out of reset.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    `ASSERT_PROP(label, clk, rst_n, !(expr))

`endif

@@ rtl/psc_pkg.sv @@
// Package: transaction types and fixed-point constants of the parabolic sine/cosine block.
package psc_pkg;

    typedef struct packed {
        logic               command;
        logic signed [15:0] angle;
    } t_psc_in;

    typedef struct packed {
        logic signed [15:0] value;
        logic               saturated;
    } t_psc_out;

    localparam logic CMD_SINE   = 1'b0;
    localparam logic CMD_COSINE = 1'b1;

    localparam int unsigned LATENCY = 8;

    // Q2.14 coefficients, pi/2 in Q3.12
    localparam logic signed [15:0] COEF_B      = 16'sd20861;
    localparam logic signed [13:0] COEF_C      = -14'sd6640;
    localparam logic signed [12:0] COEF_P      = 13'sd3686;
    localparam logic signed [16:0] HALF_PI_Q12 = 17'sd6434;

endpackage

@@ rtl/parabolic_sine_cosine.sv @@
// Top level: eight-stage pipelined parabolic sine/cosine approximation.
//
// channel   direction  handshake            payload
// command   in         start (busy = 0)     i_cmd    (t_psc_in)
// result    out        o_strobe, 1 cycle    o_result (t_psc_out)
//
// The strobe is the last of eight valid bits, in step with the stage-8 result register; one transaction per cycle.
// The depth is set by the chain of four multiplies, each followed by a rounding stage.
// busy is always low: the pipeline never stops and the receiver cannot stall.
// Synchronous reset clears the valid bits; transactions in flight are dropped.
module parabolic_sine_cosine
    import psc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    input  t_psc_in  i_cmd,
    output logic     o_strobe,
    output t_psc_out o_result
);

    logic [LATENCY-1:0] r_vld;

    // stage 1: cosine offset and clamp
    logic signed [16:0] n1_sum;
    logic signed [15:0] r1_x;
    logic               r1_sat;
    // stage 2: B*x and x*|x|
    logic signed [16:0] n2_xa;
    logic signed [31:0] r2_pbx;
    logic signed [33:0] r2_pxx;
    logic               r2_sat;
    // stage 3: round, C*sq
    logic signed [31:0] n3_t1r;
    logic signed [33:0] n3_sqr;
    logic signed [21:0] n3_sq;
    logic signed [19:0] r3_t1;
    logic signed [35:0] r3_p2;
    logic               r3_sat;
    // stage 4: y
    logic signed [35:0] n4_t2r;
    logic signed [19:0] n4_t2;
    logic signed [21:0] r4_y;
    logic               r4_sat;
    // stage 5: y*|y|
    logic signed [22:0] n5_ya;
    logic signed [44:0] r5_pyy;
    logic signed [21:0] r5_y;
    logic               r5_sat;
    // stage 6: d = yy - y
    logic signed [44:0] n6_yyr;
    logic signed [30:0] n6_yy;
    logic signed [31:0] r6_d;
    logic signed [21:0] r6_y;
    logic               r6_sat;
    // stage 7: P*d
    logic signed [44:0] r7_pd;
    logic signed [21:0] r7_y;
    logic               r7_sat;
    // stage 8: sum and saturate
    logic signed [44:0] n8_rpr;
    logic signed [30:0] n8_rp;
    logic signed [31:0] n8_r;
    t_psc_out           r8_out;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LATENCY-2:0], start & ~busy};
        end
    end

    assign n1_sum = {i_cmd.angle[15], i_cmd.angle} + HALF_PI_Q12;

    always_ff @(posedge i_clk) begin
        if (i_cmd.command == CMD_COSINE) begin
            if (n1_sum > 17'sd32767) begin
                r1_x   <= 16'sh7FFF;
                r1_sat <= 1'b1;
            end else begin
                r1_x   <= n1_sum[15:0];
                r1_sat <= 1'b0;
            end
        end else begin
            r1_x   <= i_cmd.angle;
            r1_sat <= 1'b0;
        end
    end

    assign n2_xa = r1_x[15] ? -{r1_x[15], r1_x} : {r1_x[15], r1_x};

    always_ff @(posedge i_clk) begin
        r2_pbx <= COEF_B * r1_x;
        r2_pxx <= r1_x * n2_xa;
        r2_sat <= r1_sat;
    end

    assign n3_t1r = r2_pbx + 32'sd2048;
    assign n3_sqr = r2_pxx + 34'sd512;
    assign n3_sq  = n3_sqr[31:10];

    always_ff @(posedge i_clk) begin
        r3_t1  <= n3_t1r[31:12];
        r3_p2  <= COEF_C * n3_sq;
        r3_sat <= r2_sat;
    end

    assign n4_t2r = r3_p2 + 36'sd8192;
    assign n4_t2  = n4_t2r[33:14];

    always_ff @(posedge i_clk) begin
        r4_y   <= {{2{r3_t1[19]}}, r3_t1} + {{2{n4_t2[19]}}, n4_t2};
        r4_sat <= r3_sat;
    end

    assign n5_ya = r4_y[21] ? -{r4_y[21], r4_y} : {r4_y[21], r4_y};

    always_ff @(posedge i_clk) begin
        r5_pyy <= r4_y * n5_ya;
        r5_y   <= r4_y;
        r5_sat <= r4_sat;
    end

    assign n6_yyr = r5_pyy + 45'sd8192;
    assign n6_yy  = n6_yyr[44:14];

    always_ff @(posedge i_clk) begin
        r6_d   <= {n6_yy[30], n6_yy} - {{10{r5_y[21]}}, r5_y};
        r6_y   <= r5_y;
        r6_sat <= r5_sat;
    end

    always_ff @(posedge i_clk) begin
        r7_pd  <= COEF_P * r6_d;
        r7_y   <= r6_y;
        r7_sat <= r6_sat;
    end

    assign n8_rpr = r7_pd + 45'sd8192;
    assign n8_rp  = n8_rpr[44:14];
    assign n8_r   = {n8_rp[30], n8_rp} + {{10{r7_y[21]}}, r7_y};

    always_ff @(posedge i_clk) begin
        priority if (n8_r > 32'sd32767) begin
            r8_out.value     <= 16'sh7FFF;
            r8_out.saturated <= 1'b1;
        end else if (n8_r < -32'sd32768) begin
            r8_out.value     <= -16'sh8000;
            r8_out.saturated <= 1'b1;
        end else begin
            r8_out.value     <= n8_r[15:0];
            r8_out.saturated <= r7_sat;
        end
    end

    assign o_strobe = r_vld[LATENCY-1];
    assign o_result = r8_out;

endmodule

@@ rtl/psc_chk.sv @@
// Port-level checker for the parabolic sine/cosine block, with its bind.
`include "assert_macros.svh"

module psc_chk
    import psc_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     start,
    input logic     busy,
    input t_psc_in  i_cmd,
    input logic     o_strobe,
    input t_psc_out o_result
);

    `ASSERT_NEVER(a_never_busy, i_clk, i_rst_n, busy)
    `ASSERT_PROP(a_start_to_strobe, i_clk, i_rst_n, start |-> ##8 o_strobe)
    `ASSERT_PROP(a_strobe_from_start, i_clk, i_rst_n, o_strobe |-> $past(start, 8))
    `ASSERT_PROP(a_sine_sat_at_rail, i_clk, i_rst_n,
        (o_strobe && o_result.saturated && $past(i_cmd.command, 8) == CMD_SINE)
        |-> (o_result.value == 16'sh7FFF || o_result.value == -16'sh8000))

endmodule

bind parabolic_sine_cosine psc_chk u_psc_chk (.*);
